@@ sv/fprx_pkg.sv @@
// ----------------------------------------------------------------------------
// fprx_pkg
// Shared types, register indexes and the CRC-16 lookup table for the
// framed packet receiver.
// ----------------------------------------------------------------------------
package fprx_pkg;

    // register indexes on the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'hAA;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'hFFFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // result kinds carried on tuser
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int OUT_DATA_W = 64;

    typedef logic [255:0][15:0] crc_table_t;

    // msb-first crc table, built at elaboration
    function automatic crc_table_t crc_table_gen();
        crc_table_t tbl;
        logic [15:0] c;
        for (int i = 0; i < 256; i++)
        begin
            c = {i[7:0], 8'h00};
            for (int k = 0; k < 8; k++)
            begin
                if (c[15])
                    c = {c[14:0], 1'b0} ^ CRC_POLY;
                else
                    c = {c[14:0], 1'b0};
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_table_gen();

    // control from the frame sequencer to the crc unit
    typedef struct packed {
        logic update;   // fold the byte into the crc
        logic restart;  // start again from the initial value
    } crc_ctrl_t;

    typedef enum logic [8:0] {
        PH_SYNC1 = 9'b000000001,
        PH_SYNC2 = 9'b000000010,
        PH_DEV   = 9'b000000100,
        PH_MSG   = 9'b000001000,
        PH_LENL  = 9'b000010000,
        PH_LENH  = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CRCL  = 9'b010000000,
        PH_CRCH  = 9'b100000000
    } phase_t;

endpackage

@@ sv/framed_packet_receiver_crc16_top.sv @@
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_top
// Sync-word deframer: header capture, payload pass-through with index and a
// CRC-16 verdict word at the end of each frame.
//
//   channel   dir  signals                          content
//   s_axis    in   tvalid tready tdata[7:0]         rx_byte
//   m_axis    out  tvalid tready tdata[63:0] tuser  payload/verdict word
//   cfg       in   cfg_we cfg_index cfg_data        sync bytes, length limit
//
// one received word per cycle; each word is decoded in the cycle it is taken
// and its result sits in the output register the cycle after
// the output register is a pipeline stage: a new word is taken whenever it is
// empty or being drained in the same cycle
// a stalled result blocks input only while the output register is full
// reset (rst_n, async) returns to sync hunting with registers at defaults
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_top
    import fprx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] payload_byte, [23:8] byte_index, [31:24] device_id,
    // [39:32] message_id, [55:40] frame_length, [56] crc_ok, rest zero
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tuser,   // [0] kind
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] max_length_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  dev_reg, dev_next;
    logic [7:0]  msg_reg, msg_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [15:0] out_index_reg, out_index_next;
    logic [7:0]  out_dev_reg, out_dev_next;
    logic [7:0]  out_msg_reg, out_msg_next;
    logic [15:0] out_len_reg, out_len_next;
    logic        out_ok_reg, out_ok_next;

    logic        in_acc;
    logic        emit;
    logic [7:0]  b;
    logic [15:0] crc;
    logic [15:0] count_inc;
    crc_ctrl_t   crc_ctrl;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign count_inc     = count_reg + 16'd1;

    fprx_crc16 u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (b),
        .crc   (crc)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_length_reg  <= MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                REG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                REG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // frame sequencer
    always_comb
    begin
        phase_next       = phase_reg;
        dev_next         = dev_reg;
        msg_next         = msg_reg;
        len_next         = len_reg;
        count_next       = count_reg;
        crc_low_next     = crc_low_reg;
        crc_ctrl.update  = 1'b0;
        crc_ctrl.restart = 1'b0;
        emit             = 1'b0;
        out_kind_next    = KIND_PAYLOAD;
        out_byte_next    = 8'h00;
        out_index_next   = 16'h0000;
        out_ok_next      = 1'b0;

        if (in_acc)
        begin
            case (phase_reg)
                PH_SYNC2:
                    phase_next = (b == sync_second_reg) ? PH_DEV : PH_SYNC1;
                PH_DEV:
                begin
                    dev_next         = b;
                    crc_ctrl.update  = 1'b1;
                    crc_ctrl.restart = 1'b1;
                    phase_next       = PH_MSG;
                end
                PH_MSG:
                begin
                    msg_next        = b;
                    crc_ctrl.update = 1'b1;
                    phase_next      = PH_LENL;
                end
                PH_LENL:
                begin
                    len_next        = {8'h00, b};
                    crc_ctrl.update = 1'b1;
                    phase_next      = PH_LENH;
                end
                PH_LENH:
                begin
                    len_next        = {b, len_reg[7:0]};
                    crc_ctrl.update = 1'b1;
                    count_next      = 16'h0000;
                    if (len_next > max_length_reg)
                        phase_next = PH_SYNC1;
                    else if (len_next == 16'h0000)
                        phase_next = PH_CRCL;   // empty frame, no payload words
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    crc_ctrl.update = 1'b1;
                    emit            = 1'b1;
                    out_byte_next   = b;
                    out_index_next  = count_reg;
                    count_next      = count_inc;
                    if (count_inc == len_reg)
                        phase_next = PH_CRCL;
                end
                PH_CRCL:
                begin
                    crc_low_next = b;
                    phase_next   = PH_CRCH;
                end
                PH_CRCH:
                begin
                    emit          = 1'b1;
                    out_kind_next = KIND_VERDICT;
                    out_ok_next   = ({b, crc_low_reg} == crc);
                    phase_next    = PH_SYNC1;
                end
                default:
                    phase_next = (b == sync_first_reg) ? PH_SYNC2 : PH_SYNC1;
            endcase
        end

        out_dev_next = dev_reg;
        out_msg_next = msg_reg;
        out_len_next = len_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            dev_reg       <= 8'h00;
            msg_reg       <= 8'h00;
            len_reg       <= 16'h0000;
            count_reg     <= 16'h0000;
            crc_low_reg   <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            dev_reg       <= dev_next;
            msg_reg       <= msg_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            crc_low_reg   <= crc_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word, loaded only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg  <= out_kind_next;
            out_byte_reg  <= out_byte_next;
            out_index_reg <= out_index_next;
            out_dev_reg   <= out_dev_next;
            out_msg_reg   <= out_msg_next;
            out_len_reg   <= out_len_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {7'h00, out_ok_reg, out_len_reg, out_msg_reg, out_dev_reg,
                            out_index_reg, out_byte_reg};

    // a payload word always yields a payload result
    a_payload_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_DATA |=> out_valid_reg && out_kind_reg == KIND_PAYLOAD)
        else $error("payload word did not produce a payload result");

    // the high crc word always yields a verdict
    a_verdict_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_CRCH |=> out_valid_reg && out_kind_reg == KIND_VERDICT)
        else $error("crc word did not produce a verdict");

    // payload index never reaches the declared length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> count_reg < len_reg)
        else $error("payload count ran past frame length");

    // input only held off while a result waits
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> out_valid_reg)
        else $error("input stalled with empty output register");

endmodule

@@ sv/fprx_crc16.sv @@
// ----------------------------------------------------------------------------
// fprx_crc16
// Running CRC-16 (poly 0x1021, msb first), one byte per cycle while update is set, by table lookup.
// ----------------------------------------------------------------------------
module fprx_crc16
    import fprx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctrl_t   ctrl,
    input  logic [7:0]  data,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;

    always_comb
    begin
        crc_base = ctrl.restart ? CRC_INIT : crc_reg;
        crc_next = {crc_base[7:0], 8'h00} ^ CRC_TABLE[crc_base[15:8] ^ data];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else if (ctrl.update)
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed packet receiver. Bytes go in on the
// input stream; a byte-level predictor follows sync hunting, header capture,
// payload indexing and the CRC-16 verdict, and every output word is compared
// field by field with the oldest predicted word. A short directed table runs
// first, then random frames, noise and broken headers under several register
// settings, with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import fprx_pkg::*;

    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 230;
    localparam int MAX_PRINTS  = 40;
    // index past the end of the register list, must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  device_id;
        logic [7:0]  message_id;
        logic [15:0] frame_length;
        logic        crc_ok;
    } out_word_t;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        out_word_t  res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;

    // predictor state
    phase_t      frame_phase;
    logic [7:0]  hdr_dev;
    logic [7:0]  hdr_msg;
    logic [15:0] hdr_len;
    logic [15:0] data_count;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [7:0]  cfg_sync_a;
    logic [7:0]  cfg_sync_b;
    logic [15:0] cfg_len_limit;

    out_word_t   awaited_words[$];
    out_word_t   blank_word;
    dir_row_t    dir_rows[21];

    bit idle_on   = 1'b1;
    bit hold_long = 1'b0;
    int err_count   = 0;
    int cycle_count = 0;
    int bytes_sent  = 0;

    framed_packet_receiver_crc16_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic out_word_t mk_word(input logic kind, input logic [7:0] pb,
                                          input logic [15:0] idx, input logic [7:0] dev,
                                          input logic [7:0] msg, input logic [15:0] len,
                                          input logic ok);
        out_word_t w;
        w.kind         = kind;
        w.payload_byte = pb;
        w.byte_index   = idx;
        w.device_id    = dev;
        w.message_id   = msg;
        w.frame_length = len;
        w.crc_ok       = ok;
        return w;
    endfunction

    // bitwise msb-first crc-16, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic void predict_rx(input logic [7:0] b, output bit made,
                                       output out_word_t w);
        made = 1'b0;
        w    = blank_word;
        case (frame_phase)
            PH_SYNC2:
                frame_phase = (b == cfg_sync_b) ? PH_DEV : PH_SYNC1;
            PH_DEV:
            begin
                hdr_dev     = b;
                crc_acc     = crc16_byte(CRC_INIT, b);
                frame_phase = PH_MSG;
            end
            PH_MSG:
            begin
                hdr_msg     = b;
                crc_acc     = crc16_byte(crc_acc, b);
                frame_phase = PH_LENL;
            end
            PH_LENL:
            begin
                hdr_len     = {8'h00, b};
                crc_acc     = crc16_byte(crc_acc, b);
                frame_phase = PH_LENH;
            end
            PH_LENH:
            begin
                hdr_len    = {b, hdr_len[7:0]};
                crc_acc    = crc16_byte(crc_acc, b);
                data_count = 16'd0;
                if (hdr_len > cfg_len_limit)
                    frame_phase = PH_SYNC1;
                else if (hdr_len == 16'd0)
                    frame_phase = PH_CRCL;
                else
                    frame_phase = PH_DATA;
            end
            PH_DATA:
            begin
                crc_acc    = crc16_byte(crc_acc, b);
                w          = mk_word(KIND_PAYLOAD, b, data_count, hdr_dev, hdr_msg,
                                     hdr_len, 1'b0);
                made       = 1'b1;
                data_count = data_count + 16'd1;
                if (data_count == hdr_len)
                    frame_phase = PH_CRCL;
            end
            PH_CRCL:
            begin
                crc_lo      = b;
                frame_phase = PH_CRCH;
            end
            PH_CRCH:
            begin
                w = mk_word(KIND_VERDICT, 8'h00, 16'd0, hdr_dev, hdr_msg, hdr_len,
                            {b, crc_lo} == crc_acc);
                made        = 1'b1;
                frame_phase = PH_SYNC1;
            end
            default:
                frame_phase = (b == cfg_sync_a) ? PH_SYNC2 : PH_SYNC1;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_word(input out_word_t got, input out_word_t want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0h, want %0h", got.kind, want.kind));
        if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %0h, want %0h",
                                      got.payload_byte, want.payload_byte));
        if (got.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d",
                                      got.byte_index, want.byte_index));
        if (got.device_id !== want.device_id)
            report_mismatch($sformatf("device_id %0h, want %0h",
                                      got.device_id, want.device_id));
        if (got.message_id !== want.message_id)
            report_mismatch($sformatf("message_id %0h, want %0h",
                                      got.message_id, want.message_id));
        if (got.frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      got.frame_length, want.frame_length));
        if (got.crc_ok !== want.crc_ok)
            report_mismatch($sformatf("crc_ok %0h, want %0h", got.crc_ok, want.crc_ok));
    endtask

    // output words, sampled at the rising edge
    always @(posedge clk)
    begin : watch
        out_word_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind         = m_axis_tuser;
            got.payload_byte = m_axis_tdata[7:0];
            got.byte_index   = m_axis_tdata[23:8];
            got.device_id    = m_axis_tdata[31:24];
            got.message_id   = m_axis_tdata[39:32];
            got.frame_length = m_axis_tdata[55:40];
            got.crc_ok       = m_axis_tdata[56];
            if (m_axis_tdata[OUT_DATA_W-1:57] !== '0)
                report_mismatch("padding bits not zero");
            if (awaited_words.size() == 0)
                report_mismatch("word with nothing awaited");
            else
                check_word(got, awaited_words.pop_front());
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin : sink
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_long = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] rx, input bit use_typed,
                             input out_word_t typed_word);
        bit        made;
        out_word_t w;
        int        gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_rx(rx, made, w);
        if (use_typed)
            awaited_words.push_back(typed_word);
        else if (made)
            awaited_words.push_back(w);
        bytes_sent++;
    endtask

    // one frame (possibly with a bad crc or an over-limit length), a burst of noise or a broken sync pair
    task automatic send_chunk(input int force_len);
        logic [7:0]  bq[$];
        logic [15:0] len;
        logic [15:0] crc;
        logic [7:0]  dev;
        logic [7:0]  msg;
        logic [7:0]  pb;
        int          sel;
        int          r;
        int          n_data;
        sel = (force_len >= 0) ? 0 : $urandom_range(0, 99);
        if (sel < 75)
        begin
            r = $urandom_range(0, 99);
            if (force_len >= 0)
                len = force_len[15:0];
            else if (r < 10)
                len = 16'd0;
            else if (r < 70)
                len = 16'($urandom_range(1, 12));
            else if (r < 85)
                len = 16'($urandom_range(13, 40));
            else if (r < 92 && cfg_len_limit <= 16'd40)
                len = cfg_len_limit;
            else if (cfg_len_limit < 16'hF000)
                len = 16'($urandom_range(int'(cfg_len_limit) + 1, 65535));
            else
                len = 16'($urandom_range(41, 60));
            dev = 8'($urandom);
            msg = 8'($urandom);
            crc = crc16_byte(CRC_INIT, dev);
            crc = crc16_byte(crc, msg);
            crc = crc16_byte(crc, len[7:0]);
            crc = crc16_byte(crc, len[15:8]);
            bq = '{cfg_sync_a, cfg_sync_b, dev, msg, len[7:0], len[15:8]};
            // a dropped frame trails up to four stray bytes
            n_data = (len <= cfg_len_limit) ? int'(len) : $urandom_range(0, 4);
            for (int i = 0; i < n_data; i++)
            begin
                pb  = 8'($urandom);
                crc = crc16_byte(crc, pb);
                bq.push_back(pb);
            end
            if (len <= cfg_len_limit)
            begin
                if (force_len < 0 && $urandom_range(0, 7) == 0)
                    crc ^= 16'($urandom_range(1, 65535));
                bq.push_back(crc[7:0]);
                bq.push_back(crc[15:8]);
            end
        end
        else if (sel < 88)
        begin
            repeat ($urandom_range(1, 6)) bq.push_back(8'($urandom));
        end
        else
        begin
            bq.push_back(cfg_sync_a);
            if ($urandom_range(0, 1))
                bq.push_back(8'($urandom));
        end
        foreach (bq[i])
            send_byte(bq[i], 1'b0, blank_word);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SYNC_FIRST:  cfg_sync_a    = data[7:0];
            REG_SYNC_SECOND: cfg_sync_b    = data[7:0];
            REG_MAX_LENGTH:  cfg_len_limit = data;
            default: ;
        endcase
    endtask

    // junk in the upper byte of the sync writes must be dropped
    task automatic apply_setting(input logic [7:0] sa, input logic [7:0] sb,
                                 input logic [15:0] lim);
        write_reg(REG_SYNC_FIRST, {8'($urandom), sa});
        write_reg(REG_SYNC_SECOND, {8'($urandom), sb});
        write_reg(REG_MAX_LENGTH, lim);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // input quiet and every awaited word delivered
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] dir_bytes[21];
        int         start_count;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SYNC_FIRST;
        cfg_data      = 16'h0000;
        cfg_sync_a    = SYNC_FIRST_RST;
        cfg_sync_b    = SYNC_SECOND_RST;
        cfg_len_limit = MAX_LENGTH_RST;
        frame_phase   = PH_SYNC1;
        hdr_dev       = 8'h00;
        hdr_msg       = 8'h00;
        hdr_len       = 16'd0;
        data_count    = 16'd0;
        crc_acc       = CRC_INIT;
        crc_lo        = 8'h00;
        blank_word    = mk_word(KIND_PAYLOAD, 8'h00, 16'd0, 8'h00, 8'h00, 16'd0, 1'b0);

        // bad second sync, rejected byte not retried, empty frame with good crc,
        // one all-ones payload byte and a bad crc
        dir_bytes = '{8'h55, 8'h55, 8'hAA, 8'h00,
                      8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h55, 8'hAA, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h00};
        foreach (dir_rows[i])
        begin
            dir_rows[i].rx    = dir_bytes[i];
            dir_rows[i].typed = 1'b0;
            dir_rows[i].res   = blank_word;
        end
        dir_rows[11].typed = 1'b1;
        dir_rows[11].res   = mk_word(KIND_VERDICT, 8'h00, 16'd0, 8'h00, 8'h00, 16'd0, 1'b1);
        dir_rows[18].typed = 1'b1;
        dir_rows[18].res   = mk_word(KIND_PAYLOAD, 8'hFF, 16'd0, 8'hFF, 8'hFF, 16'd1, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);
        settle();

        for (int p = 0; p <= 5; p++)
        begin
            case (p)
                0:
                begin
                    // long payload against a held-off output
                    hold_long = 1'b1;
                    send_chunk(300);
                end
                1: apply_setting(8'h00, 8'hFF, 16'h0000);
                2: apply_setting(8'hFF, 8'h00, 16'd20);
                3: apply_setting(8'h7E, 8'h7E, 16'd40);
                4: apply_setting(8'($urandom), 8'($urandom), 16'($urandom_range(0, 64)));
                default:
                begin
                    idle_on = 1'b0;
                    write_reg(REG_NONE, 16'hFFFF);
                    apply_setting(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST);
                end
            endcase
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_ITEMS)
                send_chunk(-1);
            settle();
        end

        if (err_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
